[rtl/skht_pkg.sv]
// ============================================================================
// skht_pkg
// Shared types, sizes and codes of the sorted key/handle table.
// ============================================================================
package skht_pkg;

    localparam int CAPACITY    = 512;
    localparam int HANDLE_BITS = 16;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam int STORE_HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [STORE_HW-1:0] t_shnd;
    typedef logic [CNT_W-1:0]    t_count;

    localparam t_cmd CMD_FIND   = 2'd0;
    localparam t_cmd CMD_INSERT = 2'd1;
    localparam t_cmd CMD_REMOVE = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

    typedef struct packed {
        t_cmd    command;
        t_key    key;
        t_handle handle;
    } t_in;

    typedef struct packed {
        t_status status;
        t_handle found_handle;
        t_count  entry_count;
    } t_out;

    typedef struct packed {
        t_key  key;
        t_shnd handle;
    } t_entry;

    typedef struct packed {
        logic idle;
        logic res_vld;
    } t_seq_stat;

endpackage

[rtl/skht_ram.sv]
// ============================================================================
// skht_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module skht_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/skht_seq.sv]
// ============================================================================
// skht_seq
// Command sequencer: linear scan with one key/handle comparator, then an
// entry-by-entry shift through the table RAM for insert and remove.
// ============================================================================
module skht_seq
    import skht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in       i_item,
    input  logic      i_res_take,
    output t_seq_stat o_stat,
    output t_out      o_res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state  r_state,   n_state;
    t_cmd    r_cmd,     n_cmd;
    t_key    r_key,     n_key;
    t_shnd   r_hnd,     n_hnd;
    t_count  r_occ,     n_occ;
    t_count  r_rd_idx,  n_rd_idx;
    t_count  r_chk_idx, n_chk_idx;
    logic    r_chk_vld, n_chk_vld;
    t_count  r_pos,     n_pos;
    logic    r_grow,    n_grow;
    t_status r_status,  n_status;
    t_shnd   r_found,   n_found;

    logic   mem_we;
    t_count mem_waddr;
    t_entry mem_wdata;
    t_count mem_raddr;
    t_entry rd_entry;
    t_count rd_dn;

    logic key_lt;
    logic key_eq;
    logic hnd_eq;
    logic stop;

    skht_ram #(
        .DEPTH(CAPACITY),
        .WIDTH($bits(t_entry))
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr[IDX_W-1:0]),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr[IDX_W-1:0]),
        .o_rdata(rd_entry)
    );

    // shared comparator
    assign key_lt = rd_entry.key < r_key;
    assign key_eq = rd_entry.key == r_key;
    assign hnd_eq = rd_entry.handle == r_hnd;

    always_comb begin
        case (r_cmd)
            CMD_FIND:   stop = !key_lt;
            CMD_INSERT: stop = !key_lt && !key_eq;
            CMD_REMOVE: stop = !key_lt && (!key_eq || hnd_eq);
            default:    stop = 1'b1;
        endcase
    end

    assign rd_dn     = r_rd_idx - CNT_W'(1);
    assign mem_raddr = (r_state == S_SHIFT && r_grow) ? rd_dn : r_rd_idx;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_hnd     = r_hnd;
        n_occ     = r_occ;
        n_rd_idx  = r_rd_idx;
        n_chk_idx = r_chk_idx;
        n_chk_vld = r_chk_vld;
        n_pos     = r_pos;
        n_grow    = r_grow;
        n_status  = r_status;
        n_found   = r_found;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = rd_entry;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = i_item.command;
                    n_key     = i_item.key;
                    n_hnd     = t_shnd'(i_item.handle);
                    n_rd_idx  = '0;
                    n_chk_vld = 1'b0;
                    n_status  = ST_NOT_FOUND;
                    n_found   = '0;
                    case (i_item.command)
                        CMD_FIND, CMD_REMOVE: begin
                            n_state = S_SCAN;
                        end
                        CMD_INSERT: begin
                            if (r_occ == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if ((r_chk_vld && stop) || (!r_chk_vld && r_rd_idx == r_occ)) begin
                    n_pos     = (r_chk_vld && stop) ? r_chk_idx : r_occ;
                    n_chk_vld = 1'b0;
                    case (r_cmd)
                        CMD_FIND: begin
                            if (r_chk_vld && stop && key_eq) begin
                                n_status = ST_OK;
                                n_found  = rd_entry.handle;
                            end
                            n_state = S_DONE;
                        end
                        CMD_INSERT: begin
                            n_grow   = 1'b1;
                            n_rd_idx = r_occ;
                            n_state  = S_SHIFT;
                        end
                        CMD_REMOVE: begin
                            if (r_chk_vld && stop && key_eq && hnd_eq) begin
                                n_grow   = 1'b0;
                                n_rd_idx = r_chk_idx + CNT_W'(1);
                                n_state  = S_SHIFT;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else if (r_rd_idx < r_occ) begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx;
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                end else begin
                    n_chk_vld = 1'b0;
                end
            end

            S_SHIFT: begin
                if (r_grow) begin
                    // move entries one place toward the end, last first
                    if (r_chk_vld) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_chk_idx + CNT_W'(1);
                    end
                    if (r_rd_idx > r_pos) begin
                        n_chk_vld = 1'b1;
                        n_chk_idx = rd_dn;
                        n_rd_idx  = rd_dn;
                    end else begin
                        n_chk_vld = 1'b0;
                    end
                    if (!r_chk_vld && r_rd_idx == r_pos) begin
                        mem_we        = 1'b1;
                        mem_waddr     = r_pos;
                        mem_wdata.key = r_key;
                        mem_wdata.handle = r_hnd;
                        n_occ         = r_occ + CNT_W'(1);
                        n_status      = ST_OK;
                        n_state       = S_DONE;
                    end
                end else begin
                    // close the gap left by the removed entry
                    if (r_chk_vld) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_chk_idx - CNT_W'(1);
                    end
                    if (r_rd_idx < r_occ) begin
                        n_chk_vld = 1'b1;
                        n_chk_idx = r_rd_idx;
                        n_rd_idx  = r_rd_idx + CNT_W'(1);
                    end else begin
                        n_chk_vld = 1'b0;
                    end
                    if (!r_chk_vld && r_rd_idx == r_occ) begin
                        n_occ    = r_occ - CNT_W'(1);
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_hnd     <= n_hnd;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_pos     <= n_pos;
        r_grow    <= n_grow;
        r_status  <= n_status;
        r_found   <= n_found;
    end

    assign o_stat.idle    = (r_state == S_IDLE);
    assign o_stat.res_vld = (r_state == S_DONE);

    assign o_res.status       = r_status;
    assign o_res.found_handle = t_handle'(r_found);
    assign o_res.entry_count  = r_occ;

endmodule

[rtl/sorted_key_handle_table_top.sv]
// ============================================================================
// sorted_key_handle_table_top
// Sorted key/handle table with find, insert and remove, one result per item.
// ============================================================================
// The table keeps up to CAPACITY (key, handle) pairs in one RAM, sorted by
// key, equal keys in insertion order. One item is worked on at a time; the
// single read port of the table RAM sets the pace. A find or remove scans
// from the first entry, one entry per cycle, and stops at the first entry
// not below the key (a remove also steps over equal keys with another
// handle). An insert scans the same way but stops past the key, then moves
// every entry behind the insertion point one place, one per cycle, and
// writes the new pair; a remove that hits closes the gap the same way.
// The scan and the shift together cover the entries once. The result sits in
// an output register, so the next item can enter while it waits to be taken.
module sorted_key_handle_table_top
    import skht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    t_seq_stat seq_stat;
    t_out      seq_res;
    logic      in_acc;
    logic      res_take;

    logic r_out_vld;
    t_out r_out;

    assign o_in_ready = seq_stat.idle;
    assign in_acc     = i_in_valid && o_in_ready;
    assign res_take   = seq_stat.res_vld && (!r_out_vld || i_out_ready);

    skht_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc),
        .i_item    (i_in_item),
        .i_res_take(res_take),
        .o_stat    (seq_stat),
        .o_res     (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= seq_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_FULL)
            |-> o_out_item.entry_count == CNT_W'(CAPACITY))
        else $error("full status with free entries");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK) |-> o_out_item.found_handle == '0)
        else $error("handle returned without a hit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("ready while an item is in work");

    a_res_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_stat.res_vld |-> !seq_stat.idle)
        else $error("pending result while idle");
`endif

endmodule

[bench/skht_table_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// skht_table_checker
// Watches both channels of the sorted key/handle table, keeps a shadow copy
// of the table, and checks every result field by field in arrival order.
// ============================================================================
module skht_table_checker
    import skht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_item,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_item,
    output int   o_fail_count,
    output int   o_due_count
);

    t_key  shadow_key [CAPACITY];
    t_shnd shadow_hnd [CAPACITY];
    int    shadow_fill = 0;
    t_out  answers_due[$];
    t_out  oldest_answer;
    int    fail_count = 0;

    assign o_fail_count = fail_count;

    // Applies one command to the shadow table and returns its answer.
    function automatic t_out shadow_apply(t_in item);
        t_out  ans;
        t_shnd hnd;
        int    i;
        int    j;
        ans        = '0;
        ans.status = ST_NOT_FOUND;
        hnd        = item.handle[STORE_HW-1:0];
        i          = 0;
        case (item.command)
            CMD_FIND: begin
                while (i < shadow_fill && shadow_key[i] < item.key) i++;
                if (i < shadow_fill && shadow_key[i] == item.key) begin
                    ans.status       = ST_OK;
                    ans.found_handle = t_handle'(shadow_hnd[i]);
                end
            end
            CMD_INSERT: begin
                if (shadow_fill >= CAPACITY) begin
                    ans.status = ST_FULL;
                end else begin
                    while (i < shadow_fill && shadow_key[i] <= item.key) i++;
                    for (j = shadow_fill; j > i; j--) begin
                        shadow_key[j] = shadow_key[j-1];
                        shadow_hnd[j] = shadow_hnd[j-1];
                    end
                    shadow_key[i] = item.key;
                    shadow_hnd[i] = hnd;
                    shadow_fill++;
                    ans.status = ST_OK;
                end
            end
            CMD_REMOVE: begin
                while (i < shadow_fill && shadow_key[i] < item.key) i++;
                while (ans.status != ST_OK && i < shadow_fill
                       && shadow_key[i] == item.key) begin
                    if (shadow_hnd[i] == hnd) begin
                        for (j = i; j + 1 < shadow_fill; j++) begin
                            shadow_key[j] = shadow_key[j+1];
                            shadow_hnd[j] = shadow_hnd[j+1];
                        end
                        shadow_fill--;
                        ans.status = ST_OK;
                    end else begin
                        i++;
                    end
                end
            end
            default: ;
        endcase
        ans.entry_count = t_count'(shadow_fill);
        return ans;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: %s mismatch at %0t: expected %0h, got %0h",
                         name, $realtime, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: result with no item pending at %0t: %p",
                                 $realtime, i_out_item);
                end else begin
                    oldest_answer = answers_due.pop_front();
                    check_field("status", 32'(oldest_answer.status),
                                32'(i_out_item.status));
                    check_field("found_handle", 32'(oldest_answer.found_handle),
                                32'(i_out_item.found_handle));
                    check_field("entry_count", 32'(oldest_answer.entry_count),
                                32'(i_out_item.entry_count));
                end
            end
            if (i_in_valid && i_in_ready)
                answers_due.push_back(shadow_apply(i_in_item));
        end
        o_due_count <= answers_due.size();
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Stimulus and verdict for the sorted key/handle table.
// ============================================================================
// Directed items cover the empty table, the key and handle extremes, equal
// keys, remove misses and the unused command. Random items then mix all
// commands on a small key/handle pool so that hits are common, fill the
// table past capacity, and work it down with mostly removes. Both sides idle at
// random except during one long quiet stretch.
module tb_top;
    import skht_pkg::*;

    localparam t_cmd CMD_UNUSED = 2'd3;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    out_ready = 1'b0;
    t_in     in_item   = '0;
    logic    in_ready;
    logic    out_valid;
    t_out    out_item;
    int      fail_count;
    int      due_count;
    bit      calm = 1'b0;

    t_key key_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h0000_0005, 32'h1234_5678, 32'hA5A5_5A5A};

    always #5 clk = ~clk;

    always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 8);

    sorted_key_handle_table_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    skht_table_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    task automatic send_item(t_cmd cmd, t_key key, t_handle hnd);
        t_in item;
        item.command = cmd;
        item.key     = key;
        item.handle  = hnd;
        if (!calm) begin
            while ($urandom_range(99) < 8) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (due_count != 0);
    endtask

    function automatic t_key pick_key();
        if ($urandom_range(3) != 0)
            return key_pool[$urandom_range(7)];
        return $urandom();
    endfunction

    function automatic t_handle pick_handle();
        if ($urandom_range(3) != 0)
            return t_handle'($urandom_range(3));
        return t_handle'($urandom_range(16'hFFFF));
    endfunction

    function automatic t_cmd pick_command(int find_pct, int insert_pct, int remove_pct);
        int r;
        r = $urandom_range(99);
        if (r < find_pct)
            return CMD_FIND;
        if (r < find_pct + insert_pct)
            return CMD_INSERT;
        if (r < find_pct + insert_pct + remove_pct)
            return CMD_REMOVE;
        return CMD_UNUSED;
    endfunction

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extremes, equal keys, remove misses, unused command
        send_item(CMD_FIND,   32'h0000_0000, 16'h0000);
        send_item(CMD_REMOVE, 32'h0000_0000, 16'h0000);
        send_item(CMD_UNUSED, 32'h0000_0000, 16'h0000);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_INSERT, 32'h0000_0000, 16'h0000);
        send_item(CMD_INSERT, 32'h0000_0005, 16'h0001);
        send_item(CMD_INSERT, 32'h0000_0005, 16'h0002);
        send_item(CMD_INSERT, 32'h0000_0005, 16'h0003);
        send_item(CMD_FIND,   32'h0000_0005, 16'h0000);
        send_item(CMD_FIND,   32'h0000_0004, 16'h0000);
        send_item(CMD_FIND,   32'hFFFF_FFFF, 16'h0000);
        send_item(CMD_REMOVE, 32'h0000_0005, 16'h0007);
        send_item(CMD_REMOVE, 32'h0000_0005, 16'h0002);
        send_item(CMD_FIND,   32'h0000_0005, 16'hFFFF);
        send_item(CMD_REMOVE, 32'h0000_0005, 16'h0001);
        send_item(CMD_FIND,   32'h0000_0005, 16'h0000);
        send_item(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_FIND,   32'hFFFF_FFFF, 16'h0000);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_INSERT, 32'h8000_0000, 16'hAAAA);
        send_item(CMD_FIND,   32'h0000_0000, 16'h5555);
        send_item(CMD_REMOVE, 32'h0000_0000, 16'h0000);
        wait_drained();

        repeat (300) send_item(pick_command(35, 35, 27), pick_key(), pick_handle());
        wait_drained();

        // fill past capacity so inserts get refused
        calm = 1'b1;
        repeat (250) send_item(CMD_INSERT, pick_key(), pick_handle());
        calm = 1'b0;
        repeat (290) send_item(CMD_INSERT, pick_key(), pick_handle());
        repeat (10) send_item(CMD_FIND, pick_key(), pick_handle());

        repeat (200) send_item(pick_command(30, 8, 60), pick_key(), pick_handle());

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
